>>> sv/pplt_pkg.sv
package pplt_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned USER_W    = 5;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;

  localparam int unsigned MAX_USERS_DEFAULT = 16;

  // Operation codes
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  localparam logic [BYTE_W-1:0] CHANNEL_RESET   = 8'd0;
  localparam logic [TIME_W-1:0] THRESHOLD_RESET = 32'd15000;

  // Packet checks
  localparam logic [BYTE_W-1:0] MIN_PACKET_BYTES = 8'd28;
  localparam logic [BYTE_W-1:0] MAGIC_FIRST      = 8'h57;
  localparam logic [BYTE_W-1:0] MAGIC_SECOND     = 8'h41;
  localparam logic [BYTE_W-1:0] PACKET_VERSION   = 8'd3;

  localparam logic [TIME_W-1:0] AGE_UNKNOWN = 32'hffff_ffff;

  // floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
  localparam int unsigned  DIV_MUL_W = 29;
  localparam int unsigned  DIV_SHIFT = 38;
  localparam int unsigned  PROD_W    = TIME_W + DIV_MUL_W;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 29'd274877907;

  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] now_ms;
    logic [BYTE_W-1:0] packet_length;
    logic [BYTE_W-1:0] magic_first;
    logic [BYTE_W-1:0] magic_second;
    logic [BYTE_W-1:0] format_version;
    logic [BYTE_W-1:0] sender_number;
    logic [BYTE_W-1:0] channel_tag;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [USER_W-1:0] user_index;
    logic              available;
    logic [TIME_W-1:0] age_seconds;
    logic              last_of_run;
  } out_item_t;

  // Tag that travels with one sweep read through the status pipeline
  typedef struct packed {
    logic              valid;
    logic [USER_W-1:0] user;
    logic              last;
    logic              seen;
  } sweep_tag_t;

endpackage

>>> sv/peer_presence_liveness_table.sv
// Peer presence liveness table: last-heard times for MaxUsers peers.
//
// Input: an item is taken at a rising edge with start high and busy low.
//   Packet item (operation 0): the header bytes are checked and, if they pass,
//   the sender's entry is stamped with now_ms. One result follows in the
//   next cycle; a stream of packets runs at one item per cycle while busy is low.
//   Sweep item (operation 1): one status per user, users 1..MaxUsers in order,
//   on consecutive cycles. Each status passes the memory read register, stage A,
//   stage B and the output register; busy stays high until the last status is
//   out. The status rate is set by the single read port of the time memory.
// Output: each result is on result_o for one cycle with result_valid_o high.
//   The receiver cannot stall, so no result is ever held back.
// Config: cfg_valid_i/cfg_ready_o write channel, always ready; index 0 is the
//   expected channel tag, index 1 the offline threshold in ms. Write only
//   while busy is low and no result is pending.
// Reset: registers go to their reset values and every seen bit clears at once,
//   so the block takes items in the first cycle after reset.
module peer_presence_liveness_table
  import pplt_pkg::*;
  #(
    parameter int unsigned MaxUsers = MAX_USERS_DEFAULT
  )
  (
    input  logic                 clk_i,
    input  logic                 rst_ni,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             item_i,
    output logic                 result_valid_o,
    output out_item_t            result_o,
    input  logic                 cfg_valid_i,
    output logic                 cfg_ready_o,
    input  logic [CFG_IDX_W-1:0] cfg_index_i,
    input  logic [CFG_DAT_W-1:0] cfg_data_i
  );

  localparam int unsigned AddrW = (MaxUsers > 1) ? $clog2(MaxUsers) : 1;
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(MaxUsers - 1);
  localparam logic [BYTE_W-1:0] MaxSender = BYTE_W'(MaxUsers);

  // Configuration registers
  logic [BYTE_W-1:0] channel_q;
  logic [TIME_W-1:0] threshold_q;

  // Seen bits, one per entry, cleared by reset
  logic [MaxUsers-1:0] seen_q;

  // Sweep sequencer
  logic              sweep_active_q;
  logic [AddrW-1:0]  addr_q;
  logic [TIME_W-1:0] sweep_now_q;
  sweep_tag_t        tag_rd_q;
  sweep_tag_t        tag_rd_d;

  // Output register
  logic      result_valid_q;
  out_item_t result_q;
  out_item_t packet_res;

  logic              take;
  logic              packet_ok;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW:0]    user_num;
  logic [TIME_W-1:0] rd_data;
  logic              unit_busy;
  logic              status_valid;
  out_item_t         status;

  assign cfg_ready_o = 1'b1;
  assign take        = start & ~busy;

  // Header checks for a presence packet
  assign packet_ok = (item_i.packet_length >= MIN_PACKET_BYTES) &&
                     (item_i.magic_first == MAGIC_FIRST) &&
                     (item_i.magic_second == MAGIC_SECOND) &&
                     (item_i.format_version == PACKET_VERSION) &&
                     (item_i.sender_number != '0) &&
                     (item_i.sender_number <= MaxSender) &&
                     (item_i.channel_tag == channel_q);

  assign wr_en   = take & (item_i.operation == OP_PACKET) & packet_ok;
  assign wr_addr = AddrW'(item_i.sender_number - BYTE_W'(1));

  // User number of the entry being read
  assign user_num = {1'b0, addr_q} + (AddrW + 1)'(1);

  // Hold busy from the sweep accept until its final status is in the output register
  assign busy = sweep_active_q | tag_rd_q.valid | unit_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q   <= CHANNEL_RESET;
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CHANNEL:   channel_q   <= cfg_data_i[BYTE_W-1:0];
        REG_THRESHOLD: threshold_q <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (wr_en) begin
      seen_q[wr_addr] <= 1'b1;
    end
  end

  // Tag for the entry read this cycle; idle cycles carry an empty tag
  always_comb begin
    tag_rd_d = '0;
    if (sweep_active_q) begin
      tag_rd_d.valid = 1'b1;
      tag_rd_d.user  = USER_W'(user_num);
      tag_rd_d.last  = (addr_q == LastAddr);
      tag_rd_d.seen  = seen_q[addr_q];
    end
  end

  // Step through all entries, one read per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_active_q <= 1'b0;
      addr_q         <= '0;
      tag_rd_q       <= '0;
    end else begin
      tag_rd_q <= tag_rd_d;
      if (take && item_i.operation == OP_SWEEP) begin
        sweep_active_q <= 1'b1;
        addr_q         <= '0;
      end else if (sweep_active_q) begin
        if (addr_q == LastAddr) begin
          sweep_active_q <= 1'b0;
        end else begin
          addr_q <= addr_q + AddrW'(1);
        end
      end
    end
  end

  // Latch the sweep's time stamp for every status of the run
  always_ff @(posedge clk_i) begin
    if (take && item_i.operation == OP_SWEEP) begin
      sweep_now_q <= item_i.now_ms;
    end
  end

  pplt_ram #(
    .Width (TIME_W),
    .Depth (MaxUsers)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (item_i.now_ms),
    .re_i    (sweep_active_q),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  pplt_age_unit u_age_unit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tag_i          (tag_rd_q),
    .last_seen_i    (rd_data),
    .now_i          (sweep_now_q),
    .threshold_i    (threshold_q),
    .busy_o         (unit_busy),
    .status_valid_o (status_valid),
    .status_o       (status)
  );

  // Packet verdict: rejected packets carry zeros except the run marker
  always_comb begin
    packet_res             = '0;
    packet_res.last_of_run = 1'b1;
    if (packet_ok) begin
      packet_res.accepted   = 1'b1;
      packet_res.user_index = USER_W'(item_i.sender_number);
      packet_res.available  = 1'b1;
    end
  end

  // Output register: packet verdicts and sweep statuses never overlap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= status_valid | (take & (item_i.operation == OP_PACKET));
    end
  end

  always_ff @(posedge clk_i) begin
    if (status_valid) begin
      result_q <= status;
    end else if (take && item_i.operation == OP_PACKET) begin
      result_q <= packet_res;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

>>> sv/pplt_ram.sv
module pplt_ram
  #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16,
    localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
  )
  (
    input  logic             clk_i,
    input  logic             we_i,
    input  logic [AddrW-1:0] waddr_i,
    input  logic [Width-1:0] wdata_i,
    input  logic             re_i,
    input  logic [AddrW-1:0] raddr_i,
    output logic [Width-1:0] rdata_o
  );

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/pplt_age_unit.sv
module pplt_age_unit
  import pplt_pkg::*;
  (
    input  logic              clk_i,
    input  logic              rst_ni,
    input  sweep_tag_t        tag_i,
    input  logic [TIME_W-1:0] last_seen_i,
    input  logic [TIME_W-1:0] now_i,
    input  logic [TIME_W-1:0] threshold_i,
    output logic              busy_o,
    output logic              status_valid_o,
    output out_item_t         status_o
  );

  // Stage A: age and threshold compare
  sweep_tag_t        tag_a_q;
  logic              avail_a_q;
  logic [TIME_W-1:0] age_a_q;
  logic [TIME_W-1:0] age_d;

  // Stage B: reciprocal product
  sweep_tag_t        tag_b_q;
  logic              avail_b_q;
  logic [PROD_W-1:0] prod_b_q;
  logic [PROD_W-1:0] prod_d;

  assign age_d  = now_i - last_seen_i;
  assign prod_d = PROD_W'(age_a_q) * PROD_W'(DIV_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    avail_a_q <= (age_d <= threshold_i);
    age_a_q   <= age_d;
    avail_b_q <= avail_a_q;
    prod_b_q  <= prod_d;
  end

  always_comb begin
    status_o             = '0;
    status_o.accepted    = 1'b0;
    status_o.user_index  = tag_b_q.user;
    status_o.last_of_run = tag_b_q.last;
    if (tag_b_q.seen) begin
      status_o.available   = avail_b_q;
      status_o.age_seconds = TIME_W'(prod_b_q[PROD_W-1:DIV_SHIFT]);
    end else begin
      status_o.available   = 1'b0;
      status_o.age_seconds = AGE_UNKNOWN;
    end
  end

  assign status_valid_o = tag_b_q.valid;
  assign busy_o         = tag_a_q.valid | tag_b_q.valid;

endmodule
